>>> rtl/core/tard_pkg.sv
// shared types and constants for the time axis residual decoder
// no dependencies; imported by every module of the block
`default_nettype none

package tard_pkg;

  // largest run length the block supports, capped by the 20-bit index
  localparam int unsigned MaxCoords  = 1048576;
  localparam int unsigned IndexLimit = 1048576;
  localparam logic [20:0] CountLim   =
    21'(MaxCoords < IndexLimit ? MaxCoords : IndexLimit);

  localparam int unsigned CfgIdxW = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegEpoch = 4'd0;
  localparam logic [CfgIdxW-1:0] RegStep  = 4'd1;
  localparam logic [CfgIdxW-1:0] RegWidth = 4'd2;
  localparam logic [CfgIdxW-1:0] RegCount = 4'd3;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StFail = 2'd1,
    StPad  = 2'd2
  } status_e;

  // one cycle of field cutting, seen by the prediction stage
  typedef struct packed {
    logic        complete;
    logic        pad_nz;
    logic [63:0] acc;
  } field_t;

  typedef struct packed {
    logic [63:0] coordinate;
    logic [19:0] coord_index;
    status_e     status;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/time_axis_residual_decoder.sv
// Time axis residual decoder: rebuilds signed 64-bit coordinates from a packed
// stream of zigzag residuals around the line epoch + index * step.
//
// Input channel (in_valid_i / in_ready_o / data_byte_i) takes one stream byte per
// request, bits used LSB first. Output channel (out_valid_o / out_ready_i) gives
// one coordinate per completed field (index, status, last) until its run fails.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 epoch, 1 step, 2 residual_bits, 3 coord_count); any write to one of them
// restarts the run. Write only while no byte or result is in flight.
//
// Each cycle that the output register does not stall, the field cutter either
// finishes one field or takes in the rest of the current byte, so a byte stays
// in the byte register until every field that ends in it is done, and its tail
// is taken in on its own when it starts a new field. Throughput is bounded by
// the single output register. A result passes the byte register and then the
// output register on its way out.
// A stalled receiver holds the output register; the cutter keeps absorbing
// bytes that finish no field and waits at the next field that yields a result.
// Reset: epoch 0, step 0, residual_bits 1, coord_count 1, empty pipeline.
`default_nettype none

module time_axis_residual_decoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tard_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]                  cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [7:0]                   data_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [63:0]                       coordinate_o,
  output logic [19:0]                       coord_index_o,
  output logic [1:0]                        status_o,
  output logic                              last_o
);
  import tard_pkg::*;

  logic [63:0] epoch_q, step_q;
  logic [6:0]  rbits_q;
  logic [20:0] ccount_q;
  logic        restart;
  logic [63:0] epoch_new;
  logic [6:0]  width_eff;
  logic [20:0] count_eff;
  logic [19:0] count_m1;

  field_t      field;
  result_t     result;
  result_t     out_q;
  logic        out_valid_q;
  logic        out_free;
  logic        emit;
  logic        is_last;
  logic        advance;
  logic        fire;
  logic        byte_valid;
  logic        load_out;

  assign restart   = cfg_we_i && (cfg_idx_i <= RegCount);
  assign epoch_new = (cfg_we_i && cfg_idx_i == RegEpoch) ? cfg_wdata_i : epoch_q;

  assign width_eff = (rbits_q == 7'd0) ? 7'd1 : (rbits_q > 7'd64) ? 7'd64 : rbits_q;
  assign count_eff = (ccount_q == 21'd0) ? 21'd1 :
                     (ccount_q > CountLim) ? CountLim : ccount_q;
  assign count_m1  = 20'(count_eff - 21'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q  <= '0;
      step_q   <= '0;
      rbits_q  <= 7'd1;
      ccount_q <= 21'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEpoch: epoch_q  <= cfg_wdata_i;
        RegStep:  step_q   <= cfg_wdata_i;
        RegWidth: rbits_q  <= cfg_wdata_i[6:0];
        RegCount: ccount_q <= cfg_wdata_i[20:0];
        default:  ;
      endcase
    end
  end

  // a cycle may proceed unless it has a result and the output slot is busy
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = out_free || !emit;
  assign load_out = fire && emit;

  tard_unpack u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .width_i      (width_eff),
    .advance_i    (advance),
    .is_last_i    (is_last),
    .restart_i    (restart),
    .field_o      (field),
    .byte_valid_o (byte_valid),
    .fire_o       (fire)
  );

  tard_predict u_predict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .field_i    (field),
    .take_i     (fire && field.complete),
    .restart_i  (restart),
    .epoch_i    (epoch_new),
    .step_i     (step_q),
    .count_m1_i (count_m1),
    .result_o   (result),
    .emit_o     (emit),
    .is_last_o  (is_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coordinate_o  = out_q.coordinate;
  assign coord_index_o = out_q.coord_index;
  assign status_o      = out_q.status;
  assign last_o        = out_q.last;

  // never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !load_out)
    else $error("result register overwritten while stalled");

  // input stalls only while a byte is being worked on
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> byte_valid)
    else $error("input stalled with empty byte register");

  // padding status only ever marks the final coordinate
  a_pad_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && result.status == StPad |-> result.last)
    else $error("padding status on a coordinate that is not last");

  // an out of range coordinate is reported as zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && result.status == StFail |=> coordinate_o == 64'd0)
    else $error("failed coordinate not zero");

endmodule

`default_nettype wire

>>> rtl/core/tard_unpack.sv
// byte register and field cutter: one field or one byte tail per fire_o cycle
// depends on tard_pkg
`default_nettype none

module tard_unpack (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic [6:0]    width_i,
  input  wire logic          advance_i,
  input  wire logic          is_last_i,
  input  wire logic          restart_i,
  output tard_pkg::field_t   field_o,
  output logic               byte_valid_o,
  output logic               fire_o
);
  import tard_pkg::*;

  logic [7:0]  byte_q;
  logic        bvalid_q, bvalid_d;
  logic [2:0]  pos_q, pos_d;
  logic [63:0] acc_q, acc_d;
  logic [5:0]  bc_q, bc_d;

  logic [6:0]  needed;
  logic [3:0]  avail;
  logic [3:0]  take;
  logic [3:0]  end_pos;
  logic [8:0]  low_mask;
  logic [7:0]  bits;
  logic [63:0] acc_new;
  logic        complete;
  logic        byte_done;
  logic        accept;

  assign needed   = width_i - {1'b0, bc_q};
  assign avail    = 4'd8 - {1'b0, pos_q};
  assign complete = bvalid_q && (needed <= {3'b0, avail});
  assign take     = complete ? needed[3:0] : avail;
  assign end_pos  = {1'b0, pos_q} + take;
  assign low_mask = (9'd1 << take) - 9'd1;
  assign bits     = (byte_q >> pos_q) & low_mask[7:0];
  assign acc_new  = acc_q | (64'(bits) << bc_q);

  // after the last field of a run the rest of the byte is padding
  assign byte_done = !complete || (end_pos == 4'd8) || is_last_i;
  assign fire_o    = bvalid_q && advance_i;
  assign in_ready_o = !bvalid_q || (fire_o && byte_done);
  assign accept    = in_valid_i && in_ready_o;

  assign field_o.complete = complete;
  assign field_o.pad_nz   = |(byte_q >> end_pos);
  assign field_o.acc      = acc_new;
  assign byte_valid_o     = bvalid_q;

  always_comb begin
    bvalid_d = bvalid_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    bc_d     = bc_q;
    if (fire_o) begin
      if (byte_done) begin
        bvalid_d = 1'b0;
        pos_d    = 3'd0;
      end else begin
        pos_d = end_pos[2:0];
      end
      if (complete) begin
        acc_d = '0;
        bc_d  = '0;
      end else begin
        acc_d = acc_new;
        bc_d  = bc_q + {2'b0, take};
      end
    end
    if (accept) begin
      bvalid_d = 1'b1;
      pos_d    = 3'd0;
    end
    if (restart_i) begin
      acc_d = '0;
      bc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      pos_q    <= '0;
      acc_q    <= '0;
      bc_q     <= '0;
    end else begin
      bvalid_q <= bvalid_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      bc_q     <= bc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tard_predict.sv
// 86-bit linear prediction, zigzag decode, range check and run tracking
// depends on tard_pkg
`default_nettype none

module tard_predict (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tard_pkg::field_t field_i,
  input  wire logic          take_i,
  input  wire logic          restart_i,
  input  wire logic [63:0]   epoch_i,
  input  wire logic [63:0]   step_i,
  input  wire logic [19:0]   count_m1_i,
  output tard_pkg::result_t  result_o,
  output logic               emit_o,
  output logic               is_last_o
);
  import tard_pkg::*;

  logic [63:0] pl_q, pl_d;
  logic [21:0] ph_q, ph_d;
  logic [19:0] idx_q, idx_d;
  logic        failed_q, failed_d;

  logic [63:0] residual;
  logic [64:0] lo_sum;
  logic [21:0] hi_sum;
  logic [64:0] nx_lo;
  logic [21:0] nx_hi;
  logic        fits;

  assign residual = (field_i.acc >> 1) ^ {64{field_i.acc[0]}};
  assign lo_sum   = {1'b0, pl_q} + {1'b0, residual};
  assign hi_sum   = ph_q + {21'b0, lo_sum[64]} + {22{residual[63]}};
  assign fits     = (hi_sum == {22{lo_sum[63]}});

  assign nx_lo = {1'b0, pl_q} + {1'b0, step_i};
  assign nx_hi = ph_q + {21'b0, nx_lo[64]} + {22{step_i[63]}};

  assign is_last_o = (idx_q == count_m1_i);
  assign emit_o    = field_i.complete && !failed_q;

  always_comb begin
    result_o.coordinate  = fits ? lo_sum[63:0] : 64'd0;
    result_o.coord_index = idx_q;
    result_o.last        = is_last_o;
    if (!fits) begin
      result_o.status = StFail;
    end else if (is_last_o && field_i.pad_nz) begin
      result_o.status = StPad;
    end else begin
      result_o.status = StOk;
    end
  end

  always_comb begin
    pl_d     = pl_q;
    ph_d     = ph_q;
    idx_d    = idx_q;
    failed_d = failed_q;
    if (restart_i || (take_i && is_last_o)) begin
      pl_d     = epoch_i;
      ph_d     = {22{epoch_i[63]}};
      idx_d    = '0;
      failed_d = 1'b0;
    end else if (take_i) begin
      pl_d     = nx_lo[63:0];
      ph_d     = nx_hi;
      idx_d    = idx_q + 20'd1;
      failed_d = failed_q || !fits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q     <= '0;
      ph_q     <= '0;
      idx_q    <= '0;
      failed_q <= 1'b0;
    end else begin
      pl_q     <= pl_d;
      ph_q     <= ph_d;
      idx_q    <= idx_d;
      failed_q <= failed_d;
    end
  end

endmodule

`default_nettype wire

>>> dv/time_axis_residual_decoder_tb.sv
// testbench for time_axis_residual_decoder: directed and random byte streams
// checked against a bit-exact predictor of the decoded coordinates
// depends on rtl/core/tard_pkg.sv and rtl/core/time_axis_residual_decoder.sv
`timescale 1ns / 100ps

module time_axis_residual_decoder_tb;
  import tard_pkg::*;

  localparam logic [CfgIdxW-1:0] RegNone = '1;  // not a register, write is dropped
  localparam logic [63:0] Int64Min = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int DrainCycles = 24;
  localparam int HoldCycles = 300;
  localparam int RandomBytesPerPhase = 45;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [63:0] coordinate_o;
  logic [19:0] coord_index_o;
  logic [1:0] status_o;
  logic last_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold_req = 1'b0;
  int mismatches = 0;
  result_t coords_due[$];

  // predictor copy of the registers and run state
  logic [63:0] cfg_epoch;
  logic [63:0] cfg_step;
  logic [6:0] cfg_width;
  logic [20:0] cfg_count;
  logic [63:0] field_bits;
  int unsigned field_len;
  int unsigned run_pos;
  logic [85:0] line_value;  // epoch + index * step, kept wide
  bit run_dead;

  time_axis_residual_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coordinate_o (coordinate_o),
    .coord_index_o(coord_index_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void restart_run();
    field_bits = '0;
    field_len = 0;
    run_pos = 0;
    run_dead = 1'b0;
    line_value = {{22{cfg_epoch[63]}}, cfg_epoch};
  endfunction

  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > 64) return 64;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_count();
    if (cfg_count == 0) return 1;
    if (cfg_count > CountLim) return CountLim;
    return cfg_count;
  endfunction

  function automatic void apply_register(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    case (idx)
      RegEpoch: cfg_epoch = value;
      RegStep:  cfg_step = value;
      RegWidth: cfg_width = value[6:0];
      RegCount: cfg_count = value[20:0];
      default:  return;
    endcase
    restart_run();
  endfunction

  // cut the byte into fields and queue the coordinates they produce
  function automatic void decode_byte(logic [7:0] b);
    logic [63:0] residual;
    logic [85:0] sum;
    bit fits;
    bit is_last;
    result_t r;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) field_bits[field_len] = 1'b1;
      field_len++;
      if (field_len < eff_width()) continue;
      residual = (field_bits >> 1) ^ {64{field_bits[0]}};
      sum = line_value + {{22{residual[63]}}, residual};
      fits = (sum[85:63] == '0) || (sum[85:63] == '1);
      is_last = (run_pos + 1 >= eff_count());
      if (!run_dead) begin
        r.coordinate = fits ? sum[63:0] : 64'd0;
        r.coord_index = 20'(run_pos);
        r.status = fits ? StOk : StFail;
        // padding after the final field must be zero
        if (is_last && fits && k < 7 && (b >> (k + 1)) != 8'd0) r.status = StPad;
        r.last = is_last;
        coords_due = {coords_due, r};
        if (!fits) run_dead = 1'b1;
      end
      line_value = line_value + {{22{cfg_step[63]}}, cfg_step};
      run_pos++;
      field_bits = '0;
      field_len = 0;
      if (is_last) begin
        restart_run();
        break;
      end
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (coords_due.size() == 0) begin
        $error("unexpected coordinate %h at index %0d", coordinate_o, coord_index_o);
        mismatches++;
      end else begin
        due = coords_due.pop_front();
        if (coordinate_o !== due.coordinate) begin
          $error("coordinate: expected %h, got %h", due.coordinate, coordinate_o);
          mismatches++;
        end
        if (coord_index_o !== due.coord_index) begin
          $error("coord_index: expected %0d, got %0d", due.coord_index, coord_index_o);
          mismatches++;
        end
        if (status_o !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status_o);
          mismatches++;
        end
        if (last_o !== due.last) begin
          $error("last: expected %0d, got %0d", due.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // receiver with random stalls and an occasional long hold-off
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b);
  endtask

  // let every queued coordinate out and give the cutter time to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (coords_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    apply_register(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_axis(input logic [63:0] epoch_v, input logic [63:0] step_v,
                          input logic [63:0] width_v, input logic [63:0] count_v);
    write_reg(RegEpoch, epoch_v);
    write_reg(RegStep, step_v);
    write_reg(RegWidth, width_v);
    write_reg(RegCount, count_v);
  endtask

  function automatic logic [63:0] pick_wide();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return Int64Min;
      1: return Int64Max;
      2: return '1;
      3: return '0;
      4, 5, 6: return {$urandom, $urandom};
      default: return {{32{r[31]}}, r};
    endcase
  endfunction

  task automatic random_config();
    logic [63:0] v;
    int r;
    int unsigned max_n;
    if ($urandom_range(99) < 60) write_reg(RegEpoch, pick_wide());
    if ($urandom_range(99) < 60) write_reg(RegStep, pick_wide());
    r = $urandom_range(99);
    v = {$urandom, $urandom};
    if (r < 5) v[6:0] = '0;
    else if (r < 10) v[6:0] = 7'($urandom_range(65, 127));
    else if (r < 20) v[6:0] = 7'd64;
    else if (r < 30) v[6:0] = 7'd1;
    else v[6:0] = 7'($urandom_range(1, 64));
    write_reg(RegWidth, v);
    // keep runs to a couple of dozen bytes
    max_n = 192 / eff_width();
    if (max_n > 16) max_n = 16;
    v = {$urandom, $urandom};
    v[20:0] = ($urandom_range(99) < 5) ? 21'd0 : 21'($urandom_range(1, max_n));
    write_reg(RegCount, v);
    if ($urandom_range(99) < 10)
      write_reg(CfgIdxW'($urandom_range(RegCount + 1, 2 ** CfgIdxW - 1)), {$urandom, $urandom});
  endtask

  // one complete run: packed zigzag fields, then padding to the byte edge
  task automatic send_run(ref int sent);
    logic [63:0] zz;
    logic [63:0] mask;
    logic [7:0] b;
    int unsigned w;
    int unsigned nbits;
    int r;
    bit dirty;
    w = eff_width();
    mask = (w == 64) ? '1 : (64'd1 << w) - 64'd1;
    b = '0;
    nbits = 0;
    dirty = ($urandom_range(99) < 30);
    for (int i = 0; i < eff_count(); i++) begin
      r = $urandom_range(99);
      if (r < 70) zz = 64'($urandom_range(0, 15));
      else if (r < 90) zz = {$urandom, $urandom};
      else zz = '1;
      zz &= mask;
      for (int j = 0; j < w; j++) begin
        b[nbits] = zz[j];
        nbits++;
        if (nbits == 8) begin
          send_byte(b);
          sent++;
          nbits = 0;
        end
      end
    end
    if (nbits != 0) begin
      for (int j = nbits; j < 8; j++) b[j] = dirty ? 1'($urandom_range(1)) : 1'b0;
      send_byte(b);
      sent++;
    end
  endtask

  task automatic test_reset_values();
    send_byte(8'hFF);
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_single_bit_fields();
    set_axis(Int64Min, 64'd1, 64'd1, 64'd8);
    send_byte(8'h5A);
    drain();
  endtask

  task automatic test_full_width_field();
    set_axis(64'd0, Int64Max, 64'd64, 64'd1);
    repeat (8) send_byte(8'hFF);
    drain();
  endtask

  // second prediction lies past int64, the residual pulls it back
  task automatic test_wide_prediction();
    set_axis(Int64Max, 64'd2, 64'd8, 64'd2);
    send_byte(8'h01);
    send_byte(8'h05);
    drain();
  endtask

  task automatic test_padding();
    set_axis(64'd100, 64'd10, 64'd3, 64'd2);
    send_byte(8'h42);
    send_byte(8'h3F);
    drain();
  endtask

  task automatic test_out_of_range();
    // failing field drops the rest of its run, next run starts clean
    set_axis(Int64Max, 64'd0, 64'd4, 64'd3);
    send_byte(8'h22);
    send_byte(8'hF0);
    send_byte(8'h10);
    drain();
    // failure on the last field keeps its status despite dirty padding
    set_axis(Int64Min, 64'd0, 64'd4, 64'd1);
    send_byte(8'hF1);
    drain();
  endtask

  task automatic test_register_limits();
    // zero width and zero count behave as one
    set_axis(64'd5, 64'd0, 64'd0, 64'd0);
    send_byte(8'h03);
    drain();
    // oversized width and count are clamped
    write_reg(RegWidth, '1);
    write_reg(RegCount, '1);
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_ignored_index();
    set_axis(64'd0, 64'd0, 64'd12, 64'd2);
    send_byte(8'h02);
    drain();
    write_reg(RegNone, '1);
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_axis(64'd0, 64'd1, 64'd1, 64'd8);
    long_hold_req = 1'b1;
    repeat (32) send_byte(8'($urandom));
    drain();
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct);
    int sent;
    bit fresh;
    sent = 0;
    fresh = 1'b1;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < RandomBytesPerPhase) begin
      if (fresh || $urandom_range(1) == 0) begin
        drain();
        random_config();
      end
      fresh = 1'b0;
      send_run(sent);
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom));
          sent++;
        end
        fresh = 1'b1;
      end
    end
    drain();
  endtask

  task automatic test_random_streams();
    random_phase(0, 0);
    random_phase(65, 0);
    random_phase(0, 65);
    random_phase(28, 28);
  endtask

  initial begin
    cfg_epoch = '0;
    cfg_step = '0;
    cfg_width = 7'd1;
    cfg_count = 21'd1;
    restart_run();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_single_bit_fields();
    test_full_width_field();
    test_wide_prediction();
    test_padding();
    test_out_of_range();
    test_register_limits();
    test_ignored_index();
    test_output_backpressure();
    test_random_streams();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tard_pkg.sv
rtl/core/tard_unpack.sv
rtl/core/tard_predict.sv
rtl/core/time_axis_residual_decoder.sv
dv/time_axis_residual_decoder_tb.sv
